// File: rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define DTQ_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define DTQ_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/dtq_pkg.sv
// Shared types and constants of the delta timer queue.
package dtq_pkg;

  localparam int unsigned DefaultDepth = 32;
  localparam int unsigned TagW         = 8;
  localparam int unsigned DeltaW       = 16;

  typedef enum logic [2:0] {
    ACT_INSERT   = 3'd0,
    ACT_TICK     = 3'd1,
    ACT_POP_SIG  = 3'd2,
    ACT_POP      = 3'd3,
    ACT_REM_SEM  = 3'd4,
    ACT_REM_THR  = 3'd5,
    ACT_RELEASE  = 3'd6
  } action_e;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [TagW-1:0]   thread;
    logic [TagW-1:0]   sem;
    logic [DeltaW-1:0] delta;
  } entry_t;

endpackage

// File: rtl/delta_timer_queue.sv
// Delta timer queue: operations that search walk the stored entries one by one.
// Insert searches for the slot, shifts later entries up and writes the new one;
// tick decrements a nonzero head delta; removals and release-all compact the queue,
// release-all after a counting pass; outputs wait out stalls. One item at a time.
// Each entry visit is a read then a use/write on the entry RAM's read and write ports.
// Reset empties the queue; RAM contents are not cleared and unwritten words are never used.
module delta_timer_queue
  import dtq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = DefaultDepth
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [2:0]        action_i,
  input  logic [TagW-1:0]   thread_tag_i,
  input  logic [TagW-1:0]   sem_tag_i,
  input  logic [DeltaW-1:0] delay_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [1:0]        status_o,
  output logic [TagW-1:0]   thread_out_o,
  output logic [TagW-1:0]   sem_out_o,
  output logic              signal_sem_o,
  output logic              head_expired_o,
  output logic              last_o
);

  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned IW = $clog2(QUEUE_DEPTH);
  localparam logic [CW-1:0] Full = CW'(QUEUE_DEPTH);

  typedef enum logic [12:0] {
    S_IDLE    = 13'h0001,
    S_SRCH_RD = 13'h0002,
    S_SRCH_EX = 13'h0004,
    S_SHF_RD  = 13'h0008,
    S_SHF_EX  = 13'h0010,
    S_INS_WR  = 13'h0020,
    S_TICK_RD = 13'h0040,
    S_TICK_EX = 13'h0080,
    S_PRE_RD  = 13'h0100,
    S_PRE_EX  = 13'h0200,
    S_CMP_RD  = 13'h0400,
    S_CMP_EX  = 13'h0800,
    S_FIN     = 13'h1000
  } state_e;

  state_e            state_q, state_d;
  action_e           op_q, op_d;
  logic [TagW-1:0]   th_q, th_d, se_q, se_d;
  logic [DeltaW-1:0] dly_q, dly_d;
  logic [CW-1:0]     cnt_q, cnt_d, idx_q, idx_d, wp_q, wp_d, pos_q, pos_d;
  logic [CW-1:0]     nmatch_q, nmatch_d, emitted_q, emitted_d;
  logic [DeltaW:0]   before_q, before_d;
  logic [DeltaW-1:0] carry_q, carry_d;
  logic              head_zero_q, head_zero_d;
  logic              found_q, found_d;
  logic              allz_q, allz_d, seen_q, seen_d, exp_q, exp_d;
  logic [1:0]        stat_q, stat_d;
  logic [TagW-1:0]   rth_q, rth_d, rse_q, rse_d;

  logic              ovld_q, ovld_d;
  logic [1:0]        ostat_q, ostat_d;
  logic [TagW-1:0]   oth_q, oth_d, ose_q, ose_d;
  logic              osig_q, osig_d, oexp_q, oexp_d, olast_q, olast_d;

  logic              we;
  logic [IW-1:0]     waddr, raddr;
  entry_t            wdata, rdata;

  logic              can_put, hit, keep;
  logic [DeltaW:0]   walk_sum, sat_sum;
  logic [DeltaW-1:0] sat_val, new_delta;
  logic [CW-1:0]     idx_m1;

  dtq_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign can_put    = !ovld_q || out_ready_i;
  assign idx_m1     = idx_q - CW'(1);
  assign walk_sum   = before_q + {1'b0, rdata.delta};
  assign sat_sum    = {1'b0, rdata.delta} + {1'b0, carry_q};
  assign sat_val    = sat_sum[DeltaW] ? {DeltaW{1'b1}} : sat_sum[DeltaW-1:0];
  assign new_delta  = dly_q - before_q[DeltaW-1:0];
  assign raddr      = (state_q == S_SHF_RD) ? idx_m1[IW-1:0] : idx_q[IW-1:0];

  always_comb begin
    unique case (op_q)
      ACT_POP_SIG, ACT_POP: hit = 1'b1;
      ACT_REM_SEM, ACT_RELEASE: hit = (rdata.sem == se_q);
      ACT_REM_THR: hit = (rdata.thread == th_q);
      default: hit = 1'b0;
    endcase
    keep = !(hit && (op_q == ACT_RELEASE || !found_q));
  end

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    th_d        = th_q;
    se_d        = se_q;
    dly_d       = dly_q;
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    wp_d        = wp_q;
    pos_d       = pos_q;
    nmatch_d    = nmatch_q;
    emitted_d   = emitted_q;
    before_d    = before_q;
    carry_d     = carry_q;
    head_zero_d = head_zero_q;
    found_d     = found_q;
    allz_d      = allz_q;
    seen_d      = seen_q;
    exp_d       = exp_q;
    stat_d      = stat_q;
    rth_d       = rth_q;
    rse_d       = rse_q;
    ovld_d      = ovld_q && !out_ready_i;
    ostat_d     = ostat_q;
    oth_d       = oth_q;
    ose_d       = ose_q;
    osig_d      = osig_q;
    oexp_d      = oexp_q;
    olast_d     = olast_q;
    we          = 1'b0;
    waddr       = wp_q[IW-1:0];
    wdata       = rdata;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d      = action_e'(action_i);
          th_d      = thread_tag_i;
          se_d      = sem_tag_i;
          dly_d     = delay_i;
          idx_d     = '0;
          wp_d      = '0;
          before_d  = '0;
          carry_d   = '0;
          found_d   = 1'b0;
          rth_d     = '0;
          rse_d     = '0;
          nmatch_d  = '0;
          emitted_d = '0;
          allz_d    = 1'b1;
          seen_d    = 1'b0;
          exp_d     = 1'b0;
          stat_d    = ST_EMPTY;
          unique case (action_i)
            ACT_INSERT: begin
              if (cnt_q == Full) begin
                stat_d  = ST_FULL;
                state_d = S_FIN;
              end else begin
                state_d = S_SRCH_RD;
              end
            end
            ACT_TICK: state_d = (cnt_q == '0) ? S_FIN : S_TICK_RD;
            ACT_POP_SIG, ACT_POP, ACT_REM_SEM, ACT_REM_THR: state_d = S_CMP_RD;
            ACT_RELEASE: state_d = S_PRE_RD;
            default: state_d = S_FIN;
          endcase
        end
      end

      S_SRCH_RD: begin
        if (idx_q == cnt_q) begin
          pos_d   = idx_q;
          idx_d   = cnt_q;
          state_d = S_SHF_RD;
        end else begin
          state_d = S_SRCH_EX;
        end
      end

      S_SRCH_EX: begin
        if (walk_sum < {1'b0, dly_q}) begin
          before_d = walk_sum;
          idx_d    = idx_q + CW'(1);
          state_d  = S_SRCH_RD;
        end else begin
          pos_d   = idx_q;
          idx_d   = cnt_q;
          state_d = S_SHF_RD;
        end
      end

      S_SHF_RD: begin
        state_d = (idx_q == pos_q) ? S_INS_WR : S_SHF_EX;
      end

      S_SHF_EX: begin
        // Move one entry up; the old entry at the slot becomes the successor.
        we    = 1'b1;
        waddr = idx_q[IW-1:0];
        wdata = rdata;
        if (idx_q == pos_q + CW'(1)) begin
          wdata.delta = rdata.delta - new_delta;
        end
        idx_d   = idx_m1;
        state_d = S_SHF_RD;
      end

      S_INS_WR: begin
        we           = 1'b1;
        waddr        = pos_q[IW-1:0];
        wdata.thread = th_q;
        wdata.sem    = se_q;
        wdata.delta  = new_delta;
        cnt_d        = cnt_q + CW'(1);
        if (pos_q == '0) begin
          head_zero_d = (new_delta == '0);
        end
        stat_d  = ST_OK;
        state_d = S_FIN;
      end

      S_TICK_RD: state_d = S_TICK_EX;

      S_TICK_EX: begin
        we    = 1'b1;
        waddr = '0;
        wdata = rdata;
        if (rdata.delta != '0) begin
          wdata.delta = rdata.delta - DeltaW'(1);
        end
        head_zero_d = (wdata.delta == '0);
        stat_d      = ST_OK;
        state_d     = S_FIN;
      end

      S_PRE_RD: begin
        if (idx_q == cnt_q) begin
          idx_d   = '0;
          state_d = S_CMP_RD;
        end else begin
          state_d = S_PRE_EX;
        end
      end

      S_PRE_EX: begin
        // Count matches and work out the head state after the release.
        if (hit) begin
          nmatch_d = nmatch_q + CW'(1);
          if (!seen_q) begin
            allz_d = allz_q && (rdata.delta == '0);
          end
        end else if (!seen_q) begin
          seen_d = 1'b1;
          exp_d  = allz_q && (rdata.delta == '0);
        end
        idx_d   = idx_q + CW'(1);
        state_d = S_PRE_RD;
      end

      S_CMP_RD: begin
        if (idx_q == cnt_q) begin
          cnt_d = wp_q;
          if (op_q == ACT_RELEASE && nmatch_q != '0) begin
            state_d = S_IDLE;
          end else begin
            stat_d  = found_q ? ST_OK : ST_EMPTY;
            state_d = S_FIN;
          end
        end else begin
          state_d = S_CMP_EX;
        end
      end

      S_CMP_EX: begin
        if (keep) begin
          we          = 1'b1;
          waddr       = wp_q[IW-1:0];
          wdata       = rdata;
          wdata.delta = sat_val;
          if (wp_q == '0) begin
            head_zero_d = (sat_val == '0);
          end
          wp_d    = wp_q + CW'(1);
          carry_d = '0;
          idx_d   = idx_q + CW'(1);
          state_d = S_CMP_RD;
        end else if (op_q != ACT_RELEASE) begin
          found_d = 1'b1;
          rth_d   = rdata.thread;
          rse_d   = rdata.sem;
          carry_d = sat_val;
          idx_d   = idx_q + CW'(1);
          state_d = S_CMP_RD;
        end else if (can_put) begin
          ovld_d    = 1'b1;
          ostat_d   = ST_OK;
          oth_d     = rdata.thread;
          ose_d     = rdata.sem;
          osig_d    = 1'b0;
          oexp_d    = exp_q;
          olast_d   = (emitted_q + CW'(1) == nmatch_q);
          emitted_d = emitted_q + CW'(1);
          carry_d   = sat_val;
          idx_d     = idx_q + CW'(1);
          state_d   = S_CMP_RD;
        end
      end

      S_FIN: begin
        if (can_put) begin
          ovld_d  = 1'b1;
          ostat_d = stat_q;
          oth_d   = rth_q;
          ose_d   = rse_q;
          osig_d  = found_q && (op_q == ACT_POP_SIG);
          oexp_d  = (cnt_q != '0) && head_zero_q;
          olast_d = 1'b1;
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      head_zero_q <= 1'b0;
      ovld_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      head_zero_q <= head_zero_d;
      ovld_q      <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    th_q      <= th_d;
    se_q      <= se_d;
    dly_q     <= dly_d;
    idx_q     <= idx_d;
    wp_q      <= wp_d;
    pos_q     <= pos_d;
    nmatch_q  <= nmatch_d;
    emitted_q <= emitted_d;
    before_q  <= before_d;
    carry_q   <= carry_d;
    found_q   <= found_d;
    allz_q    <= allz_d;
    seen_q    <= seen_d;
    exp_q     <= exp_d;
    stat_q    <= stat_d;
    rth_q     <= rth_d;
    rse_q     <= rse_d;
    ostat_q   <= ostat_d;
    oth_q     <= oth_d;
    ose_q     <= ose_d;
    osig_q    <= osig_d;
    oexp_q    <= oexp_d;
    olast_q   <= olast_d;
  end

  assign in_ready_o     = (state_q == S_IDLE);
  assign out_valid_o    = ovld_q;
  assign status_o       = ostat_q;
  assign thread_out_o   = oth_q;
  assign sem_out_o      = ose_q;
  assign signal_sem_o   = osig_q;
  assign head_expired_o = oexp_q;
  assign last_o         = olast_q;

endmodule

// File: rtl/dtq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module dtq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: rtl/dtq_checker.sv
// Port-level checker for the delta timer queue, bound to the top level.
`include "assert_macros.svh"

module dtq_checker
  import dtq_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input logic [1:0]        status_o,
  input logic [TagW-1:0]   thread_out_o,
  input logic [TagW-1:0]   sem_out_o,
  input logic              signal_sem_o
);

  `DTQ_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o, "result beat dropped while stalled")
  `DTQ_ASSERT_IMP(a_status_code, clk_i, rst_ni, out_valid_o, status_o == ST_OK || status_o == ST_EMPTY || status_o == ST_FULL, "status code out of range")
  `DTQ_ASSERT_IMP(a_sig_ok, clk_i, rst_ni, out_valid_o && signal_sem_o, status_o == ST_OK, "semaphore signal without a removed entry")
  `DTQ_ASSERT_IMP(a_miss_zero, clk_i, rst_ni, out_valid_o && status_o != ST_OK, thread_out_o == '0 && sem_out_o == '0, "tags set on a failed beat")

endmodule

bind delta_timer_queue dtq_checker u_dtq_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .status_o     (status_o),
  .thread_out_o (thread_out_o),
  .sem_out_o    (sem_out_o),
  .signal_sem_o (signal_sem_o)
);

// File: verif/tb_delta_timer_queue.sv
// Self-checking testbench of the delta timer queue: queued stimulus, model, beat check.
`timescale 1ns / 1ps

module tb_delta_timer_queue;
  import dtq_pkg::*;

  localparam int unsigned Depth = 32;
  localparam int unsigned StallLimit = 20000;
  localparam logic [2:0] ActUnused = 3'd7;

  typedef struct packed {
    logic [2:0]        action;
    logic [TagW-1:0]   thread;
    logic [TagW-1:0]   sem;
    logic [DeltaW-1:0] delay;
  } op_t;

  typedef struct packed {
    logic [1:0]      status;
    logic [TagW-1:0] thread;
    logic [TagW-1:0] sem;
    logic            signal;
    logic            expired;
    logic            last;
  } res_t;

  logic              clk_i, rst_ni;
  logic              in_valid_i, in_ready_o;
  logic [2:0]        action_i;
  logic [TagW-1:0]   thread_tag_i, sem_tag_i;
  logic [DeltaW-1:0] delay_i;
  logic              out_valid_o, out_ready_i;
  logic [1:0]        status_o;
  logic [TagW-1:0]   thread_out_o, sem_out_o;
  logic              signal_sem_o, head_expired_o, last_o;

  delta_timer_queue #(.QUEUE_DEPTH(Depth)) dut (.*);

  op_t    pending_ops[$];
  res_t   expected_res[$];
  entry_t sleepers[$];
  int     errors, ops_sent, beats_seen, idle_cycles, releases_multi;
  bit     stim_done;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [DeltaW-1:0] sat_add(logic [DeltaW-1:0] a, logic [DeltaW-1:0] b);
    logic [DeltaW:0] s;
    s = a + b;
    return s[DeltaW] ? '1 : s[DeltaW-1:0];
  endfunction

  function automatic void unlink(int idx);
    if (idx + 1 < sleepers.size())
      sleepers[idx+1].delta = sat_add(sleepers[idx+1].delta, sleepers[idx].delta);
    sleepers.delete(idx);
  endfunction

  // Apply one operation to the shadow queue and queue up its answers.
  function automatic void predict_sleep_queue(op_t op);
    res_t r[$];
    res_t one;
    int idx;
    logic [31:0] acc;
    entry_t e;
    bit hit;
    one = '0;
    case (op.action)
      ACT_INSERT: begin
        if (sleepers.size() >= Depth) begin
          one.status = ST_FULL;
        end else begin
          idx = 0;
          acc = 0;
          while (idx < sleepers.size() && acc + sleepers[idx].delta < op.delay) begin
            acc += sleepers[idx].delta;
            idx++;
          end
          e.thread = op.thread;
          e.sem = op.sem;
          e.delta = op.delay - acc[DeltaW-1:0];
          sleepers.insert(idx, e);
          if (idx + 1 < sleepers.size())
            sleepers[idx+1].delta = sleepers[idx+1].delta - e.delta;
          one.status = ST_OK;
        end
        r.push_back(one);
      end
      ACT_TICK: begin
        if (sleepers.size() == 0) one.status = ST_EMPTY;
        else if (sleepers[0].delta != 0) sleepers[0].delta--;
        r.push_back(one);
      end
      ACT_POP_SIG, ACT_POP: begin
        if (sleepers.size() == 0) begin
          one.status = ST_EMPTY;
        end else begin
          one.thread = sleepers[0].thread;
          one.sem = sleepers[0].sem;
          one.signal = (op.action == ACT_POP_SIG);
          unlink(0);
        end
        r.push_back(one);
      end
      ACT_REM_SEM, ACT_REM_THR: begin
        hit = 0;
        for (idx = 0; idx < sleepers.size(); idx++) begin
          if (op.action == ACT_REM_SEM ? sleepers[idx].sem == op.sem
                                        : sleepers[idx].thread == op.thread) begin
            hit = 1;
            break;
          end
        end
        if (hit) begin
          one.thread = sleepers[idx].thread;
          one.sem = sleepers[idx].sem;
          unlink(idx);
        end else begin
          one.status = ST_EMPTY;
        end
        r.push_back(one);
      end
      ACT_RELEASE: begin
        idx = 0;
        while (idx < sleepers.size()) begin
          if (sleepers[idx].sem == op.sem) begin
            one.thread = sleepers[idx].thread;
            one.sem = sleepers[idx].sem;
            r.push_back(one);
            unlink(idx);
          end else begin
            idx++;
          end
        end
        if (r.size() == 0) begin
          one.status = ST_EMPTY;
          r.push_back(one);
        end
        if (r.size() > 1) releases_multi++;
      end
      default: begin
        one.status = ST_EMPTY;
        r.push_back(one);
      end
    endcase
    foreach (r[k]) begin
      r[k].expired = sleepers.size() > 0 && sleepers[0].delta == 0;
      r[k].last = (k == r.size() - 1);
      expected_res.push_back(r[k]);
    end
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch at beat %0d: %s got %0h expected %0h", beats_seen, what, got, want);
    errors++;
  endtask

  function automatic op_t mk(logic [2:0] a, logic [7:0] t, logic [7:0] s, logic [15:0] d);
    op_t o;
    o.action = a;
    o.thread = t;
    o.sem = s;
    o.delay = d;
    return o;
  endfunction

  // Small tag pools so that removals and releases find matches.
  function automatic op_t rand_op(int fill);
    op_t o;
    int p;
    o.thread = ($urandom_range(0, 9) == 0) ? TagW'($urandom) : TagW'($urandom_range(0, 15));
    o.sem = ($urandom_range(0, 9) == 0) ? TagW'($urandom) : TagW'($urandom_range(0, 5));
    case ($urandom_range(0, 3))
      0: o.delay = DeltaW'($urandom);
      1: o.delay = DeltaW'($urandom_range(0, 3));
      2: o.delay = DeltaW'($urandom_range(65500, 65535));
      default: o.delay = DeltaW'($urandom_range(0, 200));
    endcase
    p = $urandom_range(0, 99);
    if (p < (fill ? 70 : 40)) o.action = ACT_INSERT;
    else if (p < 78) o.action = ACT_TICK;
    else if (p < 83) o.action = ACT_POP_SIG;
    else if (p < 87) o.action = ACT_POP;
    else if (p < 91) o.action = ACT_REM_SEM;
    else if (p < 95) o.action = ACT_REM_THR;
    else if (p < 99) o.action = ACT_RELEASE;
    else o.action = ActUnused;
    return o;
  endfunction

  initial begin
    int n;
    // Empty queue, full queue, saturation, release-all, unused code.
    pending_ops.push_back(mk(ACT_TICK, 0, 0, 0));
    pending_ops.push_back(mk(ACT_POP_SIG, 0, 0, 0));
    pending_ops.push_back(mk(ACT_POP, 8'hff, 8'hff, 16'hffff));
    pending_ops.push_back(mk(ACT_REM_SEM, 0, 1, 0));
    pending_ops.push_back(mk(ACT_REM_THR, 1, 0, 0));
    pending_ops.push_back(mk(ACT_RELEASE, 0, 1, 0));
    pending_ops.push_back(mk(ActUnused, 8'hff, 8'hff, 16'hffff));
    pending_ops.push_back(mk(ACT_INSERT, 8'h00, 8'h00, 16'h0000));
    pending_ops.push_back(mk(ACT_INSERT, 8'hff, 8'hff, 16'hffff));
    pending_ops.push_back(mk(ACT_INSERT, 8'h55, 8'haa, 16'hffff));
    pending_ops.push_back(mk(ACT_TICK, 0, 0, 0));
    pending_ops.push_back(mk(ACT_POP, 0, 0, 0));
    pending_ops.push_back(mk(ACT_REM_THR, 8'h55, 0, 0));
    pending_ops.push_back(mk(ACT_RELEASE, 0, 8'hff, 0));
    for (int i = 0; i < Depth + 1; i++)
      pending_ops.push_back(mk(ACT_INSERT, 8'(i), 8'(i % 3), 16'(i * 4000)));
    pending_ops.push_back(mk(ACT_RELEASE, 0, 0, 0));
    pending_ops.push_back(mk(ACT_REM_SEM, 0, 1, 0));
    pending_ops.push_back(mk(ACT_RELEASE, 0, 2, 0));
    pending_ops.push_back(mk(ACT_RELEASE, 0, 1, 0));
    n = 0;
    while (n < 360) begin
      pending_ops.push_back(rand_op((n / 60) % 2));
      n++;
    end
  end

  // Driver: bursts of random length, random gaps.
  int burst_left, gap_left;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      action_i <= '0;
      thread_tag_i <= '0;
      sem_tag_i <= '0;
      delay_i <= '0;
      burst_left <= 0;
      gap_left <= 0;
      stim_done <= 1'b0;
    end else if (!in_valid_i || in_ready_o) begin
      if (in_valid_i) begin
        predict_sleep_queue(mk(action_i, thread_tag_i, sem_tag_i, delay_i));
        ops_sent++;
      end
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid_i <= 1'b0;
      end else if (pending_ops.size() > 0) begin
        action_i <= pending_ops[0].action;
        thread_tag_i <= pending_ops[0].thread;
        sem_tag_i <= pending_ops[0].sem;
        delay_i <= pending_ops[0].delay;
        void'(pending_ops.pop_front());
        in_valid_i <= 1'b1;
        if (burst_left > 0) begin
          burst_left <= burst_left - 1;
        end else begin
          burst_left <= $urandom_range(0, 12);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
        end
      end else begin
        in_valid_i <= 1'b0;
        stim_done <= 1'b1;
      end
    end
  end

  // Monitor: own stall pattern, compare each beat against the oldest answer.
  int stall_phase;
  always @(posedge clk_i or negedge rst_ni) begin
    res_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      stall_phase <= 0;
    end else begin
      stall_phase <= stall_phase + 1;
      case ((stall_phase / 256) % 3)
        0: out_ready_i <= 1'b1;
        1: out_ready_i <= ($urandom_range(0, 2) != 0);
        default: out_ready_i <= (stall_phase % 7) < 2;
      endcase
      if (out_valid_o && out_ready_i) begin
        beats_seen++;
        if (expected_res.size() == 0) begin
          report_mismatch("unexpected beat", status_o, 0);
        end else begin
          want = expected_res.pop_front();
          if (status_o !== want.status) report_mismatch("status", status_o, want.status);
          if (thread_out_o !== want.thread) report_mismatch("thread", thread_out_o, want.thread);
          if (sem_out_o !== want.sem) report_mismatch("sem", sem_out_o, want.sem);
          if (signal_sem_o !== want.signal) report_mismatch("signal", signal_sem_o, want.signal);
          if (head_expired_o !== want.expired)
            report_mismatch("expired", head_expired_o, want.expired);
          if (last_o !== want.last) report_mismatch("last", last_o, want.last);
        end
      end
    end
  end

  // Watchdog on cycles without any handshake.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= StallLimit) begin
        $display("watchdog expired");
        $display("FAILED: results differ");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (stim_done && expected_res.size() == 0);
    repeat (4 * Depth + 20) @(posedge clk_i);
    $display("%0d operations sent, %0d result beats checked, %0d multi-entry releases",
             ops_sent, beats_seen, releases_multi);
    if (errors == 0 && expected_res.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("%0d mismatches, %0d answers outstanding", errors, expected_res.size());
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
